// ===== rtl/stl_pkg.sv =====
// Package for the session table core: widths, entry layout, action and status codes.
// Used by the interfaces, the entry memory, the controller and the top level.
package stl_pkg;

  localparam int TableDepth = 16;

  localparam int NodeW = 32;
  localparam int SessW = 16;
  localparam int TimeW = 32;
  localparam int SlotW = 4;
  localparam int ActW = 2;
  localparam int StatW = 3;

  localparam logic [ActW-1:0] ActFind = 2'd0;
  localparam logic [ActW-1:0] ActCreate = 2'd1;
  localparam logic [ActW-1:0] ActRemove = 2'd2;

  localparam logic [StatW-1:0] StOk = 3'd0;
  localparam logic [StatW-1:0] StNotFound = 3'd1;
  localparam logic [StatW-1:0] StDuplicate = 3'd2;
  localparam logic [StatW-1:0] StFull = 3'd3;
  localparam logic [StatW-1:0] StInactive = 3'd4;

  typedef struct packed {
    logic [NodeW-1:0] node_id;
    logic [SessW-1:0] session_key;
    logic             proto;
    logic [TimeW-1:0] stamp;
  } entry_t;

endpackage

// ===== rtl/stl_if.sv =====
// Request and result channels of the session table core.
// Depends on stl_pkg for the field widths.
interface stl_req_if import stl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ActW-1:0]  action;
  logic [NodeW-1:0] node_id;
  logic [SessW-1:0] session_key;
  logic             proto;
  logic [SlotW-1:0] slot_in;
  logic [TimeW-1:0] now_ms;

  modport source (
    output valid, action, node_id, session_key, proto, slot_in, now_ms,
    input  ready
  );
  modport sink (
    input  valid, action, node_id, session_key, proto, slot_in, now_ms,
    output ready
  );
endinterface

interface stl_rsp_if import stl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [SlotW-1:0] slot_out;
  logic             proto_out;
  logic [TimeW-1:0] activity_out;

  modport source (
    output valid, status, slot_out, proto_out, activity_out,
    input  ready
  );
  modport sink (
    input  valid, status, slot_out, proto_out, activity_out,
    output ready
  );
endinterface

// ===== rtl/session_table_lookup_insert_remove_core.sv =====
// Session table core: find, create and remove of keyed session entries.
// Depends on stl_pkg, stl_if, stl_entry_ram and stl_ctrl.
//
//   Channel   Direction   Contents
//   req       in          action, node_id, session_key, proto, slot_in, now_ms
//   rsp       out         status, slot_out, proto_out, activity_out
//
// A find or create walks all slots through the single port of the entry memory,
// one slot per cycle.
// A find hit or a create duplicate ends the scan as soon as the matching slot is compared.
// A remove or an unused action skips the slot scan; the valid marks live in flip-flops.
// Reset clears all valid marks at once; entry memory contents are not cleared.
// A new request is taken while the previous result still waits in the output register.
module session_table_lookup_insert_remove_core import stl_pkg::*; #(
  parameter int Depth = TableDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stl_req_if.sink   req,
  stl_rsp_if.source rsp
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [IdxW-1:0] ram_addr;
  logic            ram_we;
  entry_t          ram_wdata;
  entry_t          ram_rdata;

  stl_ctrl #(
    .Depth(Depth)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .rsp        (rsp),
    .ram_addr_o (ram_addr),
    .ram_we_o   (ram_we),
    .ram_wdata_o(ram_wdata),
    .ram_rdata_i(ram_rdata)
  );

  stl_entry_ram #(
    .Depth(Depth)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .addr_i (ram_addr),
    .we_i   (ram_we),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

endmodule

// ===== rtl/stl_entry_ram.sv =====
// Single-port entry memory holding key, protocol and time stamp of each slot.
// Depends on stl_pkg for the entry layout; read data is registered.
module stl_entry_ram import stl_pkg::*; #(
  parameter int Depth = TableDepth
) (
  input  logic                                     clk_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic                                     we_i,
  input  entry_t                                   wdata_i,
  output entry_t                                   rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/stl_ctrl.sv =====
// Request sequencer: slot scan over the entry memory, valid marks and result register.
// Depends on stl_pkg and the channel interfaces in stl_if.
module stl_ctrl import stl_pkg::*; #(
  parameter int Depth = TableDepth
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  stl_req_if.sink                                      req,
  stl_rsp_if.source                                    rsp,
  output logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] ram_addr_o,
  output logic                                         ram_we_o,
  output entry_t                                       ram_wdata_o,
  input  entry_t                                       ram_rdata_i
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SEmit = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             iss_q, iss_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic             free_vld_q, free_vld_d;
  logic [IdxW-1:0]  free_idx_q, free_idx_d;
  logic [Depth-1:0] valid_q, valid_d;

  logic [ActW-1:0]  op_act_q, op_act_d;
  entry_t           op_q, op_d;

  logic [StatW-1:0] res_stat_q, res_stat_d;
  logic [SlotW-1:0] res_slot_q, res_slot_d;
  logic             res_proto_q, res_proto_d;
  logic [TimeW-1:0] res_time_q, res_time_d;

  logic             out_vld_q, out_vld_d;
  logic [StatW-1:0] out_stat_q, out_stat_d;
  logic [SlotW-1:0] out_slot_q, out_slot_d;
  logic             out_proto_q, out_proto_d;
  logic [TimeW-1:0] out_time_q, out_time_d;

  logic             match;
  logic             cmp_last;
  logic [IdxW-1:0]  rm_idx;
  logic             rm_ok;

  assign req.ready = (state_q == SIdle);
  assign rsp.valid = out_vld_q;
  assign rsp.status = out_stat_q;
  assign rsp.slot_out = out_slot_q;
  assign rsp.proto_out = out_proto_q;
  assign rsp.activity_out = out_time_q;

  assign match = cmp_vld_q && valid_q[cmp_idx_q]
                 && (ram_rdata_i.node_id == op_q.node_id)
                 && (ram_rdata_i.session_key == op_q.session_key);
  assign cmp_last = cmp_vld_q && (cmp_idx_q == LastIdx);
  assign rm_idx = IdxW'(req.slot_in);
  assign rm_ok = (int'(req.slot_in) < Depth) && valid_q[rm_idx];

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    iss_d = iss_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    free_vld_d = free_vld_q;
    free_idx_d = free_idx_q;
    valid_d = valid_q;
    op_act_d = op_act_q;
    op_d = op_q;
    res_stat_d = res_stat_q;
    res_slot_d = res_slot_q;
    res_proto_d = res_proto_q;
    res_time_d = res_time_q;
    out_vld_d = out_vld_q;
    out_stat_d = out_stat_q;
    out_slot_d = out_slot_q;
    out_proto_d = out_proto_q;
    out_time_d = out_time_q;
    ram_addr_o = idx_q;
    ram_we_o = 1'b0;
    ram_wdata_o = op_q;

    if (out_vld_q && rsp.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (req.valid) begin
          op_act_d = req.action;
          op_d.node_id = req.node_id;
          op_d.session_key = req.session_key;
          op_d.proto = req.proto;
          op_d.stamp = req.now_ms;
          res_stat_d = StNotFound;
          res_slot_d = '0;
          res_proto_d = 1'b0;
          res_time_d = '0;
          idx_d = '0;
          iss_d = 1'b1;
          cmp_vld_d = 1'b0;
          free_vld_d = 1'b0;
          case (req.action)
            ActFind, ActCreate: begin
              state_d = SScan;
            end
            ActRemove: begin
              if (rm_ok) begin
                valid_d[rm_idx] = 1'b0;
                res_stat_d = StOk;
                res_slot_d = req.slot_in;
              end else begin
                res_stat_d = StInactive;
              end
              state_d = SEmit;
            end
            default: begin
              state_d = SEmit;
            end
          endcase
        end
      end
      SScan: begin
        cmp_vld_d = iss_q;
        cmp_idx_d = idx_q;
        if (iss_q) begin
          idx_d = idx_q + 1'b1;
          iss_d = (idx_q != LastIdx);
          if (!free_vld_q && !valid_q[idx_q]) begin
            free_vld_d = 1'b1;
            free_idx_d = idx_q;
          end
        end
        if (match) begin
          if (op_act_q == ActFind) begin
            res_stat_d = StOk;
            res_slot_d = SlotW'(cmp_idx_q);
            res_proto_d = ram_rdata_i.proto;
            res_time_d = ram_rdata_i.stamp;
          end else begin
            res_stat_d = StDuplicate;
          end
          state_d = SEmit;
        end else if (cmp_last) begin
          if (op_act_q == ActFind) begin
            res_stat_d = StNotFound;
          end else if (free_vld_q) begin
            ram_we_o = 1'b1;
            ram_addr_o = free_idx_q;
            valid_d[free_idx_q] = 1'b1;
            res_stat_d = StOk;
            res_slot_d = SlotW'(free_idx_q);
            res_proto_d = op_q.proto;
            res_time_d = op_q.stamp;
          end else begin
            res_stat_d = StFull;
          end
          state_d = SEmit;
        end
      end
      SEmit: begin
        if (!out_vld_q || rsp.ready) begin
          out_vld_d = 1'b1;
          out_stat_d = res_stat_q;
          out_slot_d = res_slot_q;
          out_proto_d = res_proto_q;
          out_time_d = res_time_q;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q <= '0;
      iss_q <= 1'b0;
      cmp_vld_q <= 1'b0;
      free_vld_q <= 1'b0;
      valid_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      iss_q <= iss_d;
      cmp_vld_q <= cmp_vld_d;
      free_vld_q <= free_vld_d;
      valid_q <= valid_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    free_idx_q <= free_idx_d;
    op_act_q <= op_act_d;
    op_q <= op_d;
    res_stat_q <= res_stat_d;
    res_slot_q <= res_slot_d;
    res_proto_q <= res_proto_d;
    res_time_q <= res_time_d;
    out_stat_q <= out_stat_d;
    out_slot_q <= out_slot_d;
    out_proto_q <= out_proto_d;
    out_time_q <= out_time_d;
  end

endmodule

// ===== sim/tb_session_table_lookup_insert_remove_core.sv =====
`timescale 1ns / 1ps
// Testbench for session_table_lookup_insert_remove_core: directed and random find, create
// and remove requests plus unused actions, each result checked against a bench table.
// Depends on stl_pkg, the channel interfaces in stl_if and the core RTL.
module tb_session_table_lookup_insert_remove_core;
  import stl_pkg::*;

  localparam logic [ActW-1:0] ActUnused = 2'd3;
  localparam int RandItems = 800;
  localparam int PhaseLen = 100;
  localparam int PoolSize = 20;
  localparam int IdleLimit = 2000;
  localparam int HoldAt = 300;
  localparam int HoldCycles = 200;
  localparam int TailCycles = 40;

  typedef struct {
    logic [ActW-1:0]  action;
    logic [NodeW-1:0] node_id;
    logic [SessW-1:0] session_key;
    logic             proto;
    logic [SlotW-1:0] slot_in;
    logic [TimeW-1:0] now_ms;
    bit               drain_first;
  } sess_req_t;

  typedef struct {
    logic [StatW-1:0] status;
    logic [SlotW-1:0] slot;
    logic             proto;
    logic [TimeW-1:0] stamp;
  } sess_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  stl_req_if req_ch ();
  stl_rsp_if rsp_ch ();

  session_table_lookup_insert_remove_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  bit               tbl_used  [TableDepth];
  logic [NodeW-1:0] tbl_node  [TableDepth];
  logic [SessW-1:0] tbl_sess  [TableDepth];
  logic             tbl_proto [TableDepth];
  logic [TimeW-1:0] tbl_stamp [TableDepth];

  sess_req_t pending_reqs[$];
  sess_rsp_t expected_rsps[$];
  sess_req_t cur_req;

  int n_requests = 0;
  int n_results = 0;
  int total_reqs = 0;
  int errors = 0;
  int req_gap = 0;
  int rsp_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;
  int act_count[4];
  int status_count[8];

  function automatic int find_slot(logic [NodeW-1:0] node, logic [SessW-1:0] sess);
    for (int s = 0; s < TableDepth; s++) begin
      if (tbl_used[s] && tbl_node[s] == node && tbl_sess[s] == sess) return s;
    end
    return TableDepth;
  endfunction

  function automatic sess_rsp_t serve_request(sess_req_t r);
    sess_rsp_t res;
    int s;
    res.status = StNotFound;
    res.slot = '0;
    res.proto = 1'b0;
    res.stamp = '0;
    case (r.action)
      ActFind: begin
        s = find_slot(r.node_id, r.session_key);
        if (s < TableDepth) begin
          res.status = StOk;
          res.slot = SlotW'(s);
          res.proto = tbl_proto[s];
          res.stamp = tbl_stamp[s];
        end
      end
      ActCreate: begin
        if (find_slot(r.node_id, r.session_key) < TableDepth) begin
          res.status = StDuplicate;
        end else begin
          s = 0;
          while (s < TableDepth && tbl_used[s]) s++;
          if (s >= TableDepth) begin
            res.status = StFull;
          end else begin
            tbl_used[s] = 1'b1;
            tbl_node[s] = r.node_id;
            tbl_sess[s] = r.session_key;
            tbl_proto[s] = r.proto;
            tbl_stamp[s] = r.now_ms;
            res.status = StOk;
            res.slot = SlotW'(s);
            res.proto = r.proto;
            res.stamp = r.now_ms;
          end
        end
      end
      ActRemove: begin
        if (int'(r.slot_in) < TableDepth && tbl_used[r.slot_in]) begin
          tbl_used[r.slot_in] = 1'b0;
          res.status = StOk;
          res.slot = r.slot_in;
        end else begin
          res.status = StInactive;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_req(logic [ActW-1:0] act, logic [NodeW-1:0] node,
                                  logic [SessW-1:0] sess, logic pr, logic [SlotW-1:0] slot,
                                  logic [TimeW-1:0] now, bit drain);
    sess_req_t r;
    r.action = act;
    r.node_id = node;
    r.session_key = sess;
    r.proto = pr;
    r.slot_in = slot;
    r.now_ms = now;
    r.drain_first = drain;
    pending_reqs.push_back(r);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sess_req_t nxt;
    bit fire;
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.action <= '0;
      req_ch.node_id <= '0;
      req_ch.session_key <= '0;
      req_ch.proto <= 1'b0;
      req_ch.slot_in <= '0;
      req_ch.now_ms <= '0;
      req_gap = 0;
    end else begin
      fire = req_ch.valid && req_ch.ready;
      if (fire) begin
        expected_rsps.push_back(serve_request(cur_req));
        act_count[cur_req.action]++;
        n_requests++;
        req_gap = (n_requests % 200 >= 150) ? 0 : $urandom_range(0, 5);
      end
      if (!req_ch.valid || fire) begin
        if (req_gap > 0) begin
          req_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].drain_first || n_results == n_requests)) begin
          nxt = pending_reqs.pop_front();
          cur_req = nxt;
          req_ch.valid <= 1'b1;
          req_ch.action <= nxt.action;
          req_ch.node_id <= nxt.node_id;
          req_ch.session_key <= nxt.session_key;
          req_ch.proto <= nxt.proto;
          req_ch.slot_in <= nxt.slot_in;
          req_ch.now_ms <= nxt.now_ms;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    sess_rsp_t want;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      rsp_gap = 0;
      hold_left = 0;
    end else begin
      if (hold_left > 0) hold_left--;
      if (rsp_ch.valid && rsp_ch.ready) begin
        status_count[rsp_ch.status]++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                   $time, rsp_ch.status, rsp_ch.slot_out);
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_ch.status));
          check_field("slot_out", 32'(want.slot), 32'(rsp_ch.slot_out));
          check_field("proto_out", 32'(want.proto), 32'(rsp_ch.proto_out));
          check_field("activity_out", want.stamp, rsp_ch.activity_out);
        end
        n_results <= n_results + 1;
        rsp_gap = (n_results % 160 >= 110) ? 0 : $urandom_range(0, 5);
        if (!hold_done && n_results + 1 == HoldAt) begin
          hold_left = HoldCycles;
          hold_done = 1'b1;
        end
      end else if (rsp_gap > 0) begin
        rsp_gap--;
      end
      rsp_ch.ready <= (rsp_gap == 0 && hold_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no request or result moved for %0d cycles", $time, IdleLimit);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [NodeW-1:0] pool_node [PoolSize];
    logic [SessW-1:0] pool_sess [PoolSize];
    logic [NodeW-1:0] node;
    logic [SessW-1:0] sess;
    logic [ActW-1:0]  act;
    int phase;
    int roll;
    int k;

    phase = 0;

    add_req(ActFind, '0, '0, 1'b0, '0, '0, 1'b0);
    add_req(ActRemove, '1, '1, 1'b1, '1, '1, 1'b0);
    add_req(ActUnused, '1, '1, 1'b1, '1, '1, 1'b0);
    add_req(ActCreate, '1, '1, 1'b1, '0, '1, 1'b0);
    add_req(ActCreate, '0, '0, 1'b0, '1, '0, 1'b0);
    add_req(ActFind, '1, '1, 1'b0, '0, '0, 1'b0);
    add_req(ActFind, '0, '0, 1'b1, '1, '1, 1'b0);
    add_req(ActCreate, '1, '1, 1'b0, '0, 32'h0000_1234, 1'b0);
    add_req(ActFind, '1, '0, 1'b0, '0, '0, 1'b0);
    add_req(ActFind, '0, '1, 1'b0, '0, '0, 1'b0);
    add_req(ActRemove, 32'h0bad_cafe, 16'h5a5a, 1'b0, 4'd0, '0, 1'b0);
    add_req(ActRemove, '0, '0, 1'b0, 4'd0, '0, 1'b0);
    add_req(ActFind, '1, '1, 1'b0, '0, '0, 1'b0);
    add_req(ActCreate, 32'h1234_5678, 16'hbeef, 1'b1, '0, 32'h8000_0000, 1'b0);
    add_req(ActFind, 32'h1234_5678, 16'hbeef, 1'b0, '0, '0, 1'b0);
    add_req(ActCreate, 32'h1234_5678, 16'hbeee, 1'b0, '0, 32'h7fff_ffff, 1'b0);
    add_req(ActRemove, '0, '0, 1'b0, 4'd1, '0, 1'b1);
    add_req(ActCreate, 32'h1234_5678, 16'hbeef, 1'b0, '0, 32'h0000_0001, 1'b0);
    add_req(ActUnused, '0, '0, 1'b0, '0, '0, 1'b0);
    add_req(ActFind, 32'h1234_5678, 16'hbeee, 1'b0, '0, '0, 1'b0);

    for (int i = 0; i < PoolSize; i++) begin
      pool_node[i] = $urandom;
      pool_sess[i] = SessW'($urandom);
      if (i % 4 == 1) pool_node[i] = pool_node[i-1];
      if (i % 4 == 3) pool_sess[i] = pool_sess[i-1];
    end

    for (int i = 0; i < RandItems; i++) begin
      if (i % PhaseLen == 0) phase = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      case (phase)
        0: act = (roll < 25) ? ActFind : (roll < 85) ? ActCreate :
                 (roll < 97) ? ActRemove : ActUnused;
        1: act = (roll < 40) ? ActFind : (roll < 70) ? ActCreate :
                 (roll < 97) ? ActRemove : ActUnused;
        default: act = (roll < 30) ? ActFind : (roll < 45) ? ActCreate :
                       (roll < 97) ? ActRemove : ActUnused;
      endcase
      k = $urandom_range(0, PoolSize - 1);
      node = pool_node[k];
      sess = pool_sess[k];
      if ($urandom_range(0, 9) == 0) begin
        node = $urandom;
        sess = SessW'($urandom);
      end
      add_req(act, node, sess, 1'($urandom), SlotW'($urandom), $urandom,
              i % PhaseLen == 0);
    end
    total_reqs = pending_reqs.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_requests == total_reqs);
    wait (n_results == n_requests);
    repeat (TailCycles) @(posedge clk_i);

    if (expected_rsps.size() != 0) begin
      $display("%0t: %0d results still outstanding at the end", $time, expected_rsps.size());
      errors++;
    end
    $display("Covered %0d requests: %0d find, %0d create, %0d remove, %0d unused action.",
             n_requests, act_count[ActFind], act_count[ActCreate], act_count[ActRemove],
             act_count[ActUnused]);
    $display("Results: %0d ok, %0d not found, %0d duplicate, %0d full, %0d inactive.",
             status_count[StOk], status_count[StNotFound], status_count[StDuplicate],
             status_count[StFull], status_count[StInactive]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
